FILE: rtl/core/fbpa_pkg.sv
// shared types, codes and constants for the block pool allocator
package fbpa_pkg;

  localparam int unsigned POOL_BLOCKS_DEF  = 256;
  localparam int unsigned HEADER_BYTES_DEF = 8;

  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned HANDLE_W   = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SIZE_W;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST   = 16'd2100;
  localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RST = 9'd256;

  localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RESIZE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

  typedef struct packed {
    logic [TYPE_W-1:0]   req_type;
    logic [SIZE_W-1:0]   request_size;
    logic [HANDLE_W-1:0] block_handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
  } result_t;

  // classified request as it waits between front and back
  typedef struct packed {
    logic [TYPE_W-1:0]   kind;
    logic                too_large;
    logic                out_of_range;
    logic [HANDLE_W-1:0] handle;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  block_bytes;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic               reinit;
    logic [COUNT_W-1:0] count;
  } pool_init_t;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] biu,
                                                   input int unsigned pool);
    eff_count = (32'(biu) < pool) ? biu : COUNT_W'(pool);
  endfunction

endpackage

FILE: rtl/core/fbpa_ram.sv
// generic simple dual-port ram with registered read
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/fbpa_front.sv
// request intake: classifies each request and queues it for the back end
module fbpa_front import fbpa_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  req_t  req,
  input  cfg_t  cfg,
  input  logic  q_pop,
  output logic  busy,
  output logic  q_valid,
  output item_t q_item
);

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

  item_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic [SIZE_W-1:0] cap;
  item_t             item_in;

  assign busy    = (fill == FILL_W'(FIFO_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_item  = slots[rd_ptr];

  always_comb begin
    // payload capacity, zero when the header eats the whole block
    if (cfg.block_bytes > SIZE_W'(HEADER_BYTES)) begin
      cap = cfg.block_bytes - SIZE_W'(HEADER_BYTES);
    end else begin
      cap = '0;
    end
    item_in.kind         = req.req_type;
    item_in.too_large    = (req.request_size > cap);
    item_in.out_of_range = ({1'b0, req.block_handle} >= cfg.count);
    item_in.handle       = req.block_handle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

FILE: rtl/core/fbpa_back.sv
// free-list engine: link store, allocated marks, head and counters
module fbpa_back import fbpa_pkg::*; #(
  parameter int unsigned POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic [COUNT_W-1:0] count,
  input  pool_init_t         init,
  output logic               done,
  output result_t            result
);

  localparam int unsigned        IDX_W     = $clog2(POOL_BLOCKS);
  localparam logic [COUNT_W-1:0] RST_COUNT = eff_count(BLOCKS_IN_USE_RST, POOL_BLOCKS);

  typedef enum logic [2:0] {
    S_EXEC = 3'b001,
    S_POP  = 3'b010,
    S_FREE = 3'b100
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] free_head;
  logic               head_valid;
  logic [COUNT_W-1:0] free_count;
  logic [COUNT_W-1:0] linked_count;

  logic               pop_upd;
  logic               pop_fwd;
  logic               pop_in_pool;
  logic [COUNT_W-1:0] fwd_val;
  logic [COUNT_W-1:0] pop_link;

  // each link ram word holds the allocated mark above the next-free link
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [COUNT_W:0]   ram_wdata;
  logic [COUNT_W:0]   ram_rdata;

  logic               free_chk;
  logic               take;
  logic               alloc_go;
  logic               link_go;
  logic               can_pop;
  logic               mark_hit;
  logic               free_go;
  logic               pop_mark;
  logic               blk_in_pool;
  logic [COUNT_W-1:0] free_count_dec;
  result_t            res_next;

  fbpa_ram #(
    .WIDTH (COUNT_W + 1),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    // an in-range free reads its mark first, so it stays queued until the back end reaches S_FREE
    free_chk       = (q_item.kind == REQ_FREE) && !q_item.out_of_range;
    take           = q_valid && (((state == S_EXEC) && !free_chk) || (state == S_FREE));
    q_pop          = take;
    alloc_go       = take && (q_item.kind == REQ_ALLOC) && !q_item.too_large;
    link_go        = alloc_go && (linked_count < count);
    can_pop        = (free_count != '0) && head_valid;
    // words at or above the lazy-link frontier are not written since init
    mark_hit       = ({1'b0, q_item.handle} < linked_count) && ram_rdata[COUNT_W];
    free_go        = take && (state == S_FREE) && free_chk && mark_hit;
    blk_in_pool    = (32'(free_head) < POOL_BLOCKS);
    free_count_dec = free_count - COUNT_W'(1);
    pop_mark       = (state == S_POP) && pop_in_pool;
    pop_link       = pop_fwd ? fwd_val : ram_rdata[COUNT_W-1:0];

    ram_we    = free_go || link_go || pop_mark;
    ram_raddr = free_chk ? IDX_W'(q_item.handle) : IDX_W'(free_head);
    if (pop_mark) begin
      // the popped block keeps its link and is marked allocated
      ram_waddr = IDX_W'(free_head);
      ram_wdata = {1'b1, pop_link};
    end else if (free_go) begin
      ram_waddr = IDX_W'(q_item.handle);
      ram_wdata = {1'b0, (head_valid ? free_head : count)};
    end else begin
      // lazy init: the next never-used block points to the one after it
      ram_waddr = IDX_W'(linked_count);
      ram_wdata = {1'b0, linked_count + COUNT_W'(1)};
    end

    res_next.status         = ST_OK;
    res_next.granted_handle = '0;
    case (q_item.kind)
      REQ_ALLOC: begin
        if (q_item.too_large) begin
          res_next.status = ST_TOO_LARGE;
        end else if (can_pop) begin
          res_next.granted_handle = free_head[HANDLE_W-1:0];
        end else begin
          res_next.status = ST_NO_MEMORY;
        end
      end
      REQ_FREE: begin
        if (q_item.out_of_range) begin
          res_next.status = ST_RANGE;
        end else if (!mark_hit) begin
          res_next.status = ST_NOT_ALLOC;
        end
      end
      REQ_RESIZE: begin
        if (q_item.too_large) begin
          res_next.status = ST_TOO_LARGE;
        end else begin
          res_next.granted_handle = q_item.handle;
        end
      end
      default: begin
        res_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || init.reinit) begin
      state        <= S_EXEC;
      free_head    <= '0;
      head_valid   <= 1'b1;
      free_count   <= rst ? RST_COUNT : init.count;
      linked_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= take;
      case (state)
        S_EXEC: begin
          if (q_valid && free_chk) begin
            state <= S_FREE;
          end
          if (link_go) begin
            linked_count <= linked_count + COUNT_W'(1);
          end
          if (alloc_go) begin
            if (can_pop) begin
              free_count <= free_count_dec;
              if (free_count_dec == '0) begin
                head_valid <= 1'b0;
              end
              state <= S_POP;
            end else begin
              head_valid <= 1'b0;
            end
          end
        end
        S_POP: begin
          // new head comes from the link read issued in the previous cycle
          if (pop_upd) begin
            free_head <= pop_in_pool ? pop_link : '0;
          end
          state <= S_EXEC;
        end
        S_FREE: begin
          if (free_go) begin
            free_head  <= {1'b0, q_item.handle};
            head_valid <= 1'b1;
            free_count <= free_count + COUNT_W'(1);
          end
          state <= S_EXEC;
        end
        default: begin
          state <= S_EXEC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
    if (alloc_go && can_pop) begin
      pop_upd     <= (free_count_dec != '0);
      // the link just written this cycle is not yet visible on the read port
      pop_fwd     <= link_go && (free_head == linked_count);
      fwd_val     <= linked_count + COUNT_W'(1);
      pop_in_pool <= blk_in_pool;
    end
  end

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> state == S_EXEC)
    else $error("pop state held longer than one cycle");

  a_free_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_FREE |=> state == S_EXEC)
    else $error("free state held longer than one cycle");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= count)
    else $error("free count exceeds pool size");

  a_linked_bound: assert property (@(posedge clk) disable iff (rst)
    linked_count <= count)
    else $error("linked count exceeds pool size");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> free_count == '0)
    else $error("free blocks left with no valid head");

  a_done_follows_take: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take))
    else $error("result strobe without a request taken");

endmodule

FILE: rtl/core/fixed_block_pool_allocator_unit.sv
// block pool allocator top level: config registers, front end and free-list engine
// done and the result beat are registered when the back end takes the request from the queue
// resize and rejected requests need no extra back-end state; an in-range free passes S_FREE
//   (mark read) and a granted allocate S_POP (next head), both for the registered ram read
// a 2-entry queue holds requests between front and back; busy is high while it is full
// results come as a one-cycle done strobe; the receiver cannot stall
// reset: synchronous, restores register defaults, all blocks free and the free list unbuilt
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int unsigned POOL_BLOCKS  = POOL_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SIZE_W-1:0]  block_bytes;
  logic [COUNT_W-1:0] blocks_in_use;
  logic [COUNT_W-1:0] count;
  cfg_t               cfg;
  pool_init_t         init;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= BLOCK_BYTES_RST;
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_BYTES:   block_bytes   <= cfg_data[SIZE_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[COUNT_W-1:0];
        default:           block_bytes   <= block_bytes;
      endcase
    end
  end

  always_comb begin
    count           = eff_count(blocks_in_use, POOL_BLOCKS);
    cfg.block_bytes = block_bytes;
    cfg.count       = count;
    // a new block count rebuilds the pool
    init.reinit     = cfg_we && (cfg_index == REG_BLOCKS_IN_USE);
    init.count      = eff_count(cfg_data[COUNT_W-1:0], POOL_BLOCKS);
  end

  fbpa_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .cfg     (cfg),
    .q_pop   (q_pop),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  fbpa_back #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .count   (count),
    .init    (init),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: bench/pool_checker.sv
`timescale 1ns / 100ps
// watches the allocator's request, result and register channels and checks every result beat
module pool_checker import fbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  req_t                  req,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    compared,
  output int                    pending
);

  localparam int unsigned POOL   = POOL_BLOCKS_DEF;
  localparam int unsigned HEADER = HEADER_BYTES_DEF;

  logic [SIZE_W-1:0]  blk_bytes;
  logic [COUNT_W-1:0] blk_total;
  logic [COUNT_W-1:0] next_link [POOL];
  bit                 taken [POOL];
  logic [COUNT_W-1:0] head;
  bit                 head_live;
  int unsigned        free_left;
  int unsigned        built;
  result_t            due_results [$];
  result_t            want;

  function automatic int unsigned usable_blocks();
    return (blk_total < POOL) ? blk_total : POOL;
  endfunction

  function automatic int unsigned payload_room();
    return (blk_bytes > HEADER) ? blk_bytes - HEADER : 0;
  endfunction

  function automatic void clear_pool();
    foreach (next_link[i]) begin
      next_link[i] = '0;
      taken[i]     = 1'b0;
    end
    head      = '0;
    head_live = 1'b1;
    free_left = usable_blocks();
    built     = 0;
  endfunction

  // one request against the free list; returns the beat the block should answer with
  function automatic result_t serve(input req_t r);
    result_t     res;
    int unsigned n;
    int unsigned blk;
    n   = usable_blocks();
    res = '{status: ST_OK, granted_handle: '0};
    case (r.req_type)
      REQ_ALLOC: begin
        if (r.request_size > payload_room()) begin
          res.status = ST_TOO_LARGE;
        end else begin
          // lazy build: one never-used block joins the list per allocate
          if (built < n) begin
            next_link[built] = COUNT_W'(built + 1);
            built++;
          end
          if (free_left > 0 && head_live) begin
            blk = head;
            free_left--;
            if (free_left > 0) begin
              head = (blk < POOL) ? next_link[blk] : '0;
            end else begin
              head_live = 1'b0;
            end
            if (blk < POOL) taken[blk] = 1'b1;
            res.granted_handle = HANDLE_W'(blk);
          end else begin
            head_live  = 1'b0;
            res.status = ST_NO_MEMORY;
          end
        end
      end
      REQ_FREE: begin
        if (r.block_handle >= n) begin
          res.status = ST_RANGE;
        end else if (!taken[r.block_handle]) begin
          res.status = ST_NOT_ALLOC;
        end else begin
          next_link[r.block_handle] = head_live ? head : COUNT_W'(n);
          head                      = COUNT_W'(r.block_handle);
          head_live                 = 1'b1;
          taken[r.block_handle]     = 1'b0;
          free_left++;
        end
      end
      REQ_RESIZE: begin
        if (r.request_size > payload_room()) res.status = ST_TOO_LARGE;
        else res.granted_handle = r.block_handle;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blk_bytes = BLOCK_BYTES_RST;
      blk_total = BLOCKS_IN_USE_RST;
      clear_pool();
      due_results.delete();
      pending = 0;
    end else begin
      // compare before predicting: a beat taken now cannot answer at this edge
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d, granted_handle %0d",
                 result.status, result.granted_handle);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            errors++;
          end
          if (result.granted_handle !== want.granted_handle) begin
            $error("granted_handle: expected %0d, actual %0d",
                   want.granted_handle, result.granted_handle);
            errors++;
          end
          compared++;
        end
      end
      if (start && !busy) due_results.push_back(serve(req));
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_BYTES) begin
          blk_bytes = cfg_data;
        end else begin
          blk_total = cfg_data[COUNT_W-1:0];
          clear_pool();
        end
      end
      pending = due_results.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// allocator bench top: clock, reset, request and register traffic, and the verdict
module testbench;
  import fbpa_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int unsigned       RANDOM_REQS = 1100;
  localparam int unsigned       CYCLE_LIMIT = 200000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  req_t                  req       = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  result_t               result;

  int          errors;
  int          compared;
  int          pending;
  int unsigned idle_pct;
  int unsigned cycle_count;
  int unsigned rand_done;
  int unsigned n_alloc, n_free, n_resize, n_unused, n_settings;
  logic [SIZE_W-1:0]  cur_bytes  = BLOCK_BYTES_RST;
  logic [COUNT_W-1:0] cur_blocks = BLOCKS_IN_USE_RST;

  always #4 clk = ~clk;

  fixed_block_pool_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pool_checker watch (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .compared  (compared),
    .pending   (pending)
  );

  function automatic int unsigned room();
    return (cur_bytes > HEADER_BYTES_DEF) ? cur_bytes - HEADER_BYTES_DEF : 0;
  endfunction

  function automatic int unsigned live_blocks();
    return (cur_blocks < POOL_BLOCKS_DEF) ? cur_blocks : POOL_BLOCKS_DEF;
  endfunction

  task automatic issue(input logic [TYPE_W-1:0] kind, input logic [SIZE_W-1:0] size,
                       input logic [HANDLE_W-1:0] handle);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= '{req_type: kind, request_size: size, block_handle: handle};
    do @(posedge clk); while (busy !== 1'b0);
    case (kind)
      REQ_ALLOC:  n_alloc++;
      REQ_FREE:   n_free++;
      REQ_RESIZE: n_resize++;
      default:    n_unused++;
    endcase
  endtask

  // drop start and hold off until every beat in flight has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    // a granted allocate may still be fetching the next head after its beat
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_BLOCK_BYTES) cur_bytes = data;
    else cur_blocks = data[COUNT_W-1:0];
  endtask

  task automatic new_setting();
    logic [SIZE_W-1:0]  bytes;
    logic [COUNT_W-1:0] blocks;
    int unsigned        pick;
    pick = $urandom_range(9);
    if (pick == 0)     bytes = 16'd16;
    else if (pick == 1) bytes = 16'hFFFF;
    else if (pick < 5)  bytes = SIZE_W'($urandom_range(16, 200));
    else                bytes = SIZE_W'($urandom_range(16, 65535));
    write_reg(REG_BLOCK_BYTES, bytes);
    // some phases keep the pool and only change the block size
    if ($urandom_range(9) < 7) begin
      pick = $urandom_range(19);
      if (pick < 8)        blocks = COUNT_W'($urandom_range(1, 16));
      else if (pick < 12)  blocks = COUNT_W'($urandom_range(17, 64));
      else if (pick < 15)  blocks = 9'd256;
      else if (pick < 18)  blocks = COUNT_W'($urandom_range(65, 255));
      else if (pick == 18) blocks = 9'd1;
      else                 blocks = COUNT_W'($urandom_range(257, 511));
      write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'(blocks));
    end
    n_settings++;
  endtask

  task automatic random_request();
    int unsigned        pick;
    int unsigned        room_now;
    int unsigned        live;
    int unsigned        sz;
    int unsigned        h;
    logic [TYPE_W-1:0]  kind;
    pick     = $urandom_range(99);
    room_now = room();
    live     = live_blocks();
    if (pick < 45)      kind = REQ_ALLOC;
    else if (pick < 83) kind = REQ_FREE;
    else if (pick < 95) kind = REQ_RESIZE;
    else                kind = REQ_UNUSED;
    case ($urandom_range(9))
      0:       sz = $urandom_range(65535);
      1:       sz = room_now;
      2:       sz = room_now + 1;
      default: sz = $urandom_range(room_now);
    endcase
    // frees mostly land inside the pool so they hit live blocks
    if (live > 0 && $urandom_range(9) < 8) h = $urandom_range(live - 1);
    else h = $urandom_range(255);
    rand_done++;
    issue(kind, SIZE_W'(sz), HANDLE_W'(h));
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d beats outstanding", cycle_count, pending);
    $display("** fixed_block_pool_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    int unsigned burst;
    int unsigned k;
    idle_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset setting: 2100-byte blocks, full pool
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd2092, 8'd0);
    issue(REQ_ALLOC, 16'd2093, 8'd0);
    issue(REQ_ALLOC, 16'hFFFF, 8'hFF);
    issue(REQ_RESIZE, 16'd2092, 8'hFF);
    issue(REQ_RESIZE, 16'hFFFF, 8'd0);
    issue(REQ_FREE, 16'd0, 8'd1);
    issue(REQ_FREE, 16'd0, 8'd1);
    issue(REQ_FREE, 16'hFFFF, 8'hFF);
    issue(REQ_UNUSED, 16'hFFFF, 8'hFF);
    issue(REQ_ALLOC, 16'd100, 8'd0);
    settle();
    // two-block pool: run dry, out-of-range frees, refill
    write_reg(REG_BLOCKS_IN_USE, 16'd2);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_FREE, 16'd0, 8'd2);
    issue(REQ_FREE, 16'd0, 8'hFF);
    issue(REQ_FREE, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    settle();
    // empty pool
    write_reg(REG_BLOCKS_IN_USE, 16'd0);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_FREE, 16'd0, 8'd0);
    settle();
    // header-only and undersized blocks
    write_reg(REG_BLOCK_BYTES, 16'd8);
    write_reg(REG_BLOCKS_IN_USE, 16'd1);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd1, 8'd0);
    settle();
    write_reg(REG_BLOCK_BYTES, 16'd4);
    issue(REQ_RESIZE, 16'd0, 8'd7);
    issue(REQ_ALLOC, 16'd0, 8'd0);
    settle();
    write_reg(REG_BLOCK_BYTES, 16'hFFFF);
    issue(REQ_RESIZE, 16'd65527, 8'd128);
    issue(REQ_RESIZE, 16'd65528, 8'd128);
    issue(REQ_FREE, 16'd0, 8'd0);
    issue(REQ_ALLOC, 16'd65527, 8'd0);
    n_settings = 6;

    rand_done = 0;
    while (rand_done < RANDOM_REQS) begin
      settle();
      new_setting();
      burst = $urandom_range(60, 140);
      k = 0;
      while (k < burst && rand_done < RANDOM_REQS) begin
        if (rand_done < RANDOM_REQS / 3)          idle_pct = 14;
        else if (rand_done < 2 * RANDOM_REQS / 3) idle_pct = 46;
        else                                      idle_pct = 0;
        random_request();
        if ($urandom_range(199) == 0) settle();
        k++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    $display("requests sent: %0d allocate, %0d free, %0d resize, %0d unused code, %0d settings",
             n_alloc, n_free, n_resize, n_unused, n_settings);
    $display("%0d result beats checked against the predicted free list", compared);
    if (errors == 0) begin
      $display("** fixed_block_pool_allocator_unit: PASSED **");
    end else begin
      $display("** fixed_block_pool_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
